[rtl/bfdh_pkg.sv]
package bfdh_pkg;

	// store geometry
	localparam int MAX_BITS   = 65536;
	localparam int MIN_BITS   = 64;
	localparam int MAX_PROBES = 30;
	localparam int WORD_W     = 64;
	localparam int WORDS      = MAX_BITS / WORD_W;
	localparam int ADDR_W     = $clog2(WORDS);
	localparam int BIT_W      = $clog2(WORD_W);
	localparam int POS_W      = $clog2(MAX_BITS);

	// field widths
	localparam int HASH_W  = 64;
	localparam int NBITS_W = 17;
	localparam int K_W     = 5;
	localparam int REQ_W   = 2;
	localparam int STEP_W  = $clog2(HASH_W);

	// request codes
	typedef enum logic [REQ_W-1:0] {
		REQ_ADD   = 2'd0,
		REQ_QUERY = 2'd1,
		REQ_CLEAR = 2'd2,
		REQ_NONE  = 2'd3
	} req_t;

	// configuration register indexes
	localparam logic CFG_FILTER_BITS = 1'b0;
	localparam logic CFG_HASH_COUNT  = 1'b1;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_DIV,
		ST_READ,
		ST_CHECK,
		ST_DONE
	} state_t;

endpackage

[rtl/bloom_filter_double_hash.sv]
// Bloom filter bit store with double hashing.
// Input channel (in_valid / in_ready) carries one item: req_type (add, query,
// clear) and two 64-bit base hashes. Every item gives exactly one result on
// the output channel (out_valid / out_ready): maybe_present, which is 1 only
// for a query whose probed bits were all set.
// Configuration port: cfg_we writes cfg_wdata into register cfg_index
// (0 filter_bits, 1 hash_count); write only while the block is idle.
// Each probe runs a bit-serial 64-step restoring reduction of the probe value
// modulo filter_bits, then a read (and for an add a write) of one 64-bit word
// of the store. An add or query runs hash_count probes, with hash_count
// clamped to the range 1 to 30. A clear sweeps all 1024 store words, one
// per cycle. Unused request code 3 leaves the store alone and answers 0.
// in_ready is high only while the sequencer is idle; one item at a time.
// The result sits in an output register: a new item may be accepted while it
// waits, and a finished result waits inside the block while out_ready is low.
// After reset the block runs a clearing pass of all 1024 store words before
// in_ready rises; configuration writes are taken during that pass.
module bloom_filter_double_hash
	import bfdh_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [NBITS_W-1:0] cfg_wdata,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [REQ_W-1:0]   req_type,
	input  logic [HASH_W-1:0]  hash_a,
	input  logic [HASH_W-1:0]  hash_b,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               maybe_present
);

	localparam logic [NBITS_W-1:0] MinBits = NBITS_W'(MIN_BITS);
	localparam logic [NBITS_W-1:0] MaxBits = NBITS_W'(MAX_BITS);
	localparam logic [K_W-1:0]     MaxK    = K_W'(MAX_PROBES);
	localparam logic [ADDR_W-1:0]  LastWord = ADDR_W'(WORDS - 1);
	localparam logic [STEP_W-1:0]  LastStep = STEP_W'(HASH_W - 1);

	state_t state_q, state_d;

	logic [NBITS_W-1:0] filter_bits_q;
	logic [K_W-1:0]     hash_count_q;
	logic [NBITS_W-1:0] n_eff;
	logic [K_W-1:0]     k_eff;

	logic [ADDR_W-1:0]  clr_cnt_q;
	logic               clr_req_q;
	req_t               req_q;
	logic [HASH_W-1:0]  probe_q;
	logic [HASH_W-1:0]  dvd_q;
	logic [HASH_W-1:0]  hb_q;
	logic [HASH_W-1:0]  probe_nxt;
	logic [NBITS_W-1:0] rem_q;
	logic [NBITS_W:0]   rem_sh;
	logic [NBITS_W-1:0] rem_nxt;
	logic [STEP_W-1:0]  step_q;
	logic [K_W-1:0]     idx_q;
	logic               last_probe;
	logic               hit_q;
	logic               out_valid_q;
	logic               maybe_present_q;
	logic               accept;
	logic               done_load;

	logic [WORD_W-1:0]  store_mem [WORDS];
	logic [WORD_W-1:0]  rd_data_q;
	logic [ADDR_W-1:0]  rd_addr;
	logic [BIT_W-1:0]   bit_sel;
	logic               mem_we;
	logic [ADDR_W-1:0]  mem_waddr;
	logic [WORD_W-1:0]  mem_wdata;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_bits_q <= MinBits;
			hash_count_q  <= K_W'(6);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_FILTER_BITS: filter_bits_q <= cfg_wdata;
				CFG_HASH_COUNT:  hash_count_q  <= cfg_wdata[K_W-1:0];
				default: ;
			endcase
		end
	end

	// clamp modulus and probe count
	always_comb begin
		if (filter_bits_q < MinBits)
			n_eff = MinBits;
		else if (filter_bits_q > MaxBits)
			n_eff = MaxBits;
		else
			n_eff = filter_bits_q;
		if (hash_count_q == '0)
			k_eff = K_W'(1);
		else if (hash_count_q > MaxK)
			k_eff = MaxK;
		else
			k_eff = hash_count_q;
	end

	// shared restoring divider step and probe bookkeeping
	always_comb begin
		rem_sh     = {rem_q, dvd_q[HASH_W-1]};
		rem_nxt    = (rem_sh >= {1'b0, n_eff}) ? NBITS_W'(rem_sh - {1'b0, n_eff})
		                                       : rem_sh[NBITS_W-1:0];
		probe_nxt  = probe_q + hb_q;
		last_probe = (idx_q == k_eff - K_W'(1));
		rd_addr    = rem_q[POS_W-1:BIT_W];
		bit_sel    = rem_q[BIT_W-1:0];
		accept     = in_valid && in_ready;
		done_load  = (state_q == ST_DONE) && (!out_valid_q || out_ready);
	end

	// sequencer: next state and store write control
	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = clr_cnt_q;
		mem_wdata = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					case (req_type)
						REQ_ADD, REQ_QUERY: state_d = ST_DIV;
						REQ_CLEAR:          state_d = ST_CLEAR;
						default:            state_d = ST_DONE;
					endcase
				end
			end
			ST_CLEAR: begin
				mem_we = 1'b1;
				if (clr_cnt_q == LastWord)
					state_d = clr_req_q ? ST_DONE : ST_IDLE;
			end
			ST_DIV: begin
				if (step_q == LastStep)
					state_d = ST_READ;
			end
			ST_READ: begin
				state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (req_q == REQ_ADD) begin
					mem_we    = 1'b1;
					mem_waddr = rd_addr;
					mem_wdata = rd_data_q | (WORD_W'(1) << bit_sel);
				end
				state_d = last_probe ? ST_DONE : ST_DIV;
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state register, clearing pass runs from reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_cnt_q <= '0;
			clr_req_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR)
				clr_cnt_q <= (clr_cnt_q == LastWord) ? '0 : clr_cnt_q + ADDR_W'(1);
			if (accept)
				clr_req_q <= (req_type == REQ_CLEAR);
		end
	end

	// probe datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q   <= req_t'(req_type);
			probe_q <= hash_a;
			dvd_q   <= hash_a;
			hb_q    <= hash_b;
			rem_q   <= '0;
			step_q  <= '0;
			idx_q   <= '0;
			hit_q   <= (req_type == REQ_QUERY);
		end else if (state_q == ST_DIV) begin
			dvd_q  <= dvd_q << 1;
			rem_q  <= rem_nxt;
			step_q <= step_q + STEP_W'(1);
		end else if (state_q == ST_CHECK) begin
			if (req_q == REQ_QUERY && !rd_data_q[bit_sel])
				hit_q <= 1'b0;
			if (!last_probe) begin
				probe_q <= probe_nxt;
				dvd_q   <= probe_nxt;
				rem_q   <= '0;
				step_q  <= '0;
				idx_q   <= idx_q + K_W'(1);
			end
		end
	end

	// filter store, one word read and at most one word written per cycle
	always_ff @(posedge clk) begin
		if (mem_we)
			store_mem[mem_waddr] <= mem_wdata;
		rd_data_q <= store_mem[rd_addr];
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done_load)
			maybe_present_q <= hit_q;
	end

	assign out_valid     = out_valid_q;
	assign maybe_present = maybe_present_q;

`ifndef SYNTHESIS
	// partial remainder always below the modulus while a probe runs
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV || state_q == ST_READ || state_q == ST_CHECK) |->
		(rem_q < n_eff))
		else $error("remainder not below modulus");

	// probe index stays inside the clamped probe count
	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV || state_q == ST_CHECK) |-> (idx_q < k_eff))
		else $error("probe index out of range");

	// store only written by the clearing sweep or an add
	a_we_src: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == ST_CLEAR || (state_q == ST_CHECK && req_q == REQ_ADD)))
		else $error("unexpected store write");

	// a hit can only be reported for a query
	a_hit_query: assert property (@(posedge clk) disable iff (!arst_n)
		(done_load && hit_q) |-> (req_q == REQ_QUERY && !clr_req_q))
		else $error("hit reported for non-query item");

	// one item at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready)
		else $error("item accepted while busy");
`endif

endmodule
